[rtl/core/ppp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_pkg
// Widths, register indexes and shared constants of the pose point projection.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int P_W   = 32;  // point, translation, Q16.16
	localparam int Q_W   = 16;  // quaternion, Q1.14
	localparam int FOC_W = 16;  // focal length, Q12.4
	localparam int CEN_W = 12;  // image centre, whole pixels
	localparam int OUT_W = 32;  // pixel coordinate, Q16.16

	localparam int QP_W  = 2 * Q_W;          // quaternion products, Q.28
	localparam int M_W   = QP_W + 2;         // rotation entries, Q.28
	localparam int A_W   = M_W - 4;          // rotation entries, Q.24
	localparam int AP_W  = A_W + P_W;        // entry times point, Q.40
	localparam int ACC_W = 64;               // camera coordinate sum, Q.40
	localparam int C_W   = 38;               // camera coordinate, Q.16
	localparam int N_W   = C_W + FOC_W + 1;  // coordinate times focal length
	localparam int AN_W  = N_W - 1;          // its magnitude
	localparam int D_W   = C_W;              // depth magnitude

	localparam int INT_BITS  = 20;                    // quotient bits from the low dividend bits
	localparam int FRAC_BITS = 13;                    // quotient bits from zeros brought down
	localparam int DIV_STEPS = INT_BITS + FRAC_BITS;  // one quotient bit per stage
	localparam int VAL_W     = OUT_W + 3;

	localparam logic signed [M_W-1:0]   M_ONE     = M_W'(64'd1 << 28);
	localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(64'd1 << 23);
	localparam logic signed [VAL_W-1:0] SAT_HI    = VAL_W'(64'h7FFF_FFFF);
	localparam logic signed [VAL_W-1:0] SAT_LO    = -VAL_W'(64'h8000_0000);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(3);

	localparam logic [FOC_W-1:0] FOCAL_RST    = FOC_W'(8000);
	localparam logic [CEN_W-1:0] CENTER_X_RST = CEN_W'(320);
	localparam logic [CEN_W-1:0] CENTER_Y_RST = CEN_W'(240);

endpackage
`default_nettype wire

[rtl/core/ppp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_if
// Valid/ready channels of the pose point projection: pose input, pixel
// output and configuration write.
// ----------------------------------------------------------------------------
interface pose_in_if;
	import ppp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [P_W-1:0]   point_x;
	logic signed [P_W-1:0]   point_y;
	logic signed [P_W-1:0]   point_z;
	logic signed [Q_W-1:0]   quat_w;
	logic signed [Q_W-1:0]   quat_x;
	logic signed [Q_W-1:0]   quat_y;
	logic signed [Q_W-1:0]   quat_z;
	logic signed [P_W-1:0]   shift_x;
	logic signed [P_W-1:0]   shift_y;
	logic signed [P_W-1:0]   shift_z;
	modport source (output valid, point_x, point_y, point_z, quat_w, quat_x, quat_y,
		quat_z, shift_x, shift_y, shift_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, quat_w, quat_x, quat_y,
		quat_z, shift_x, shift_y, shift_z, output ready);
endinterface

interface pix_out_if;
	import ppp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] pixel_u;
	logic signed [OUT_W-1:0] pixel_v;
	logic                    bad_depth;
	modport source (output valid, pixel_u, pixel_v, bad_depth, input ready);
	modport sink (input valid, pixel_u, pixel_v, bad_depth, output ready);
endinterface

interface cfg_wr_if;
	import ppp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/ppp_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider: one quotient bit per stage. The quotient fits
// DIV_STEPS bits only if rem_in < d_in; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ppp_div (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [ppp_pkg::D_W-1:0]        rem_in,
	input  wire logic [ppp_pkg::D_W-1:0]        d_in,
	input  wire logic [ppp_pkg::INT_BITS-1:0]   lo_in,
	output logic      [ppp_pkg::DIV_STEPS-1:0]  quo
);
	import ppp_pkg::*;

	logic [D_W-1:0]       rem_s [DIV_STEPS];
	logic [D_W-1:0]       d_s   [DIV_STEPS];
	logic [INT_BITS-1:0]  lo_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [D_W-1:0]       rem_p;
		logic [D_W-1:0]       d_p;
		logic [INT_BITS-1:0]  lo_p;
		logic [DIV_STEPS-1:0] quo_p;
		logic [D_W:0]         trial;
		logic                 ge;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign d_p   = d_in;
			assign lo_p  = lo_in;
			assign quo_p = '0;
		end else begin : g_rest
			assign rem_p = rem_s[k-1];
			assign d_p   = d_s[k-1];
			assign lo_p  = lo_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		// bring down the next dividend bit; zeros follow once lo is used up
		assign trial = {rem_p, lo_p[INT_BITS-1]};
		assign ge    = trial >= {1'b0, d_p};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? D_W'(trial - {1'b0, d_p}) : D_W'(trial);
				d_s[k]   <= d_p;
				lo_s[k]  <= lo_p << 1;
				quo_s[k] <= {quo_p[DIV_STEPS-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule
`default_nettype wire

[rtl/core/pose_point_projection_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pose_point_projection_top
// Quaternion pose transform and pinhole projection of one point per beat.
// ----------------------------------------------------------------------------
// Takes one point and pose per clock and returns one pixel per clock while
// the output is not stalled. Six stages build the rotation
// matrix, rotate and translate, scale by focal length and take magnitudes;
// 33 stages of the restoring divider each produce one quotient bit of the
// division by depth; the last stage rounds, adds the image centre and
// saturates. A stall on the output holds the whole pipeline. Configuration
// writes take effect at once and are to be made while the block is empty.
// ----------------------------------------------------------------------------
module pose_point_projection_top (
	input  wire logic clk,
	input  wire logic arst_n,
	cfg_wr_if.sink    cfg,
	pose_in_if.sink   in_ch,
	pix_out_if.source out_ch
);
	import ppp_pkg::*;

	typedef struct packed {
		logic valid;
		logic zero;
		logic ovf_x;
		logic ovf_y;
		logic neg_x;
		logic neg_y;
		logic cneg_x;
		logic cneg_y;
	} side_t;

	logic [FOC_W-1:0] focal_x_q, focal_y_q;
	logic [CEN_W-1:0] center_x_q, center_y_q;

	logic en;

	// ---------------- configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RST;
			focal_y_q  <= FOCAL_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FOCAL_X:  focal_x_q  <= cfg.data;
				REG_FOCAL_Y:  focal_y_q  <= cfg.data;
				REG_CENTER_X: center_x_q <= cfg.data[CEN_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg.data[CEN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: quaternion products
	logic                    v_s1;
	logic signed [QP_W-1:0]  xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [P_W-1:0]   p_s1 [3];
	logic signed [P_W-1:0]   t_s1 [3];

	assign in_ch.ready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= in_ch.quat_x * in_ch.quat_x;
			yy_s1 <= in_ch.quat_y * in_ch.quat_y;
			zz_s1 <= in_ch.quat_z * in_ch.quat_z;
			xy_s1 <= in_ch.quat_x * in_ch.quat_y;
			xz_s1 <= in_ch.quat_x * in_ch.quat_z;
			yz_s1 <= in_ch.quat_y * in_ch.quat_z;
			wx_s1 <= in_ch.quat_w * in_ch.quat_x;
			wy_s1 <= in_ch.quat_w * in_ch.quat_y;
			wz_s1 <= in_ch.quat_w * in_ch.quat_z;
			p_s1[0] <= in_ch.point_x;
			p_s1[1] <= in_ch.point_y;
			p_s1[2] <= in_ch.point_z;
			t_s1[0] <= in_ch.shift_x;
			t_s1[1] <= in_ch.shift_y;
			t_s1[2] <= in_ch.shift_z;
		end
	end

	// ---------------- stage 2: rotation matrix, rounded to Q.24
	function automatic logic signed [A_W-1:0] rnd_entry(input logic signed [M_W-1:0] m);
		logic signed [M_W-1:0] r;
		r = m + M_W'(8);
		return r[A_W+3:4];
	endfunction

	function automatic logic signed [M_W-1:0] dbl(input logic signed [QP_W-1:0] a,
		input logic signed [QP_W-1:0] b, input logic sub);
		logic signed [M_W-1:0] s;
		s = sub ? (M_W'(a) - M_W'(b)) : (M_W'(a) + M_W'(b));
		return s <<< 1;
	endfunction

	logic                   v_s2;
	logic signed [A_W-1:0]  a_c  [9];
	logic signed [A_W-1:0]  a_s2 [9];
	logic signed [P_W-1:0]  p_s2 [3];
	logic signed [P_W-1:0]  t_s2 [3];

	always_comb begin
		a_c[0] = rnd_entry(M_ONE - dbl(yy_s1, zz_s1, 1'b0));
		a_c[1] = rnd_entry(dbl(xy_s1, wz_s1, 1'b1));
		a_c[2] = rnd_entry(dbl(xz_s1, wy_s1, 1'b0));
		a_c[3] = rnd_entry(dbl(xy_s1, wz_s1, 1'b0));
		a_c[4] = rnd_entry(M_ONE - dbl(xx_s1, zz_s1, 1'b0));
		a_c[5] = rnd_entry(dbl(yz_s1, wx_s1, 1'b1));
		a_c[6] = rnd_entry(dbl(xz_s1, wy_s1, 1'b1));
		a_c[7] = rnd_entry(dbl(yz_s1, wx_s1, 1'b0));
		a_c[8] = rnd_entry(M_ONE - dbl(xx_s1, yy_s1, 1'b0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_c;
			p_s2 <= p_s1;
			t_s2 <= t_s1;
		end
	end

	// ---------------- stage 3: entry times point, Q.40
	logic                   v_s3;
	logic signed [AP_W-1:0] prod_s3 [9];
	logic signed [P_W-1:0]  t_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				prod_s3[k] <= a_s2[k] * p_s2[k % 3];
			end
			t_s3 <= t_s2;
		end
	end

	// ---------------- stage 4: sum, translate, round to Q.16
	logic                   v_s4;
	logic signed [C_W-1:0]  c_c  [3];
	logic signed [C_W-1:0]  c_s4 [3];

	always_comb begin
		logic signed [ACC_W-1:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = ACC_W'(prod_s3[3*i]) + ACC_W'(prod_s3[3*i+1]) + ACC_W'(prod_s3[3*i+2])
				+ (ACC_W'(t_s3[i]) <<< 24) + ACC_HALF;
			c_c[i] = acc[C_W+23:24];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= c_c;
		end
	end

	// ---------------- stage 5: scale by focal length
	logic                   v_s5;
	logic signed [N_W-1:0]  nx_s5, ny_s5;
	logic signed [C_W-1:0]  z_s5;
	logic                   cneg_x_s5, cneg_y_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5     <= c_s4[0] * signed'({1'b0, focal_x_q});
			ny_s5     <= c_s4[1] * signed'({1'b0, focal_y_q});
			z_s5      <= c_s4[2];
			cneg_x_s5 <= c_s4[0][C_W-1];
			cneg_y_s5 <= c_s4[1][C_W-1];
		end
	end

	// ---------------- stage 6: magnitudes, overflow test, divider seed
	logic [D_W-1:0]  d_c;
	logic [AN_W-1:0] anx_c, any_c;

	assign d_c   = z_s5[C_W-1] ? D_W'(-z_s5) : D_W'(z_s5);
	assign anx_c = nx_s5[N_W-1] ? AN_W'(-nx_s5) : AN_W'(nx_s5);
	assign any_c = ny_s5[N_W-1] ? AN_W'(-ny_s5) : AN_W'(ny_s5);

	logic                 v_s6;
	logic [D_W-1:0]       d_s6;
	logic [D_W-1:0]       remx_s6, remy_s6;
	logic [INT_BITS-1:0]  lox_s6, loy_s6;
	side_t                side_c;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6    <= d_c;
			remx_s6 <= D_W'(anx_c >> INT_BITS);
			remy_s6 <= D_W'(any_c >> INT_BITS);
			lox_s6  <= anx_c[INT_BITS-1:0];
			loy_s6  <= any_c[INT_BITS-1:0];
			side_c.valid  <= v_s5;
			side_c.zero   <= (z_s5 == '0);
			side_c.ovf_x  <= (D_W+INT_BITS)'(anx_c) >= {d_c, INT_BITS'(0)};
			side_c.ovf_y  <= (D_W+INT_BITS)'(any_c) >= {d_c, INT_BITS'(0)};
			side_c.neg_x  <= nx_s5[N_W-1] ^ z_s5[C_W-1];
			side_c.neg_y  <= ny_s5[N_W-1] ^ z_s5[C_W-1];
			side_c.cneg_x <= cneg_x_s5;
			side_c.cneg_y <= cneg_y_s5;
		end
	end

	// ---------------- valid chain through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------- division by depth, side info alongside
	logic [DIV_STEPS-1:0] quox, quoy;
	side_t                side_s [DIV_STEPS];
	side_t                side_in;

	always_comb begin
		side_in       = side_c;
		side_in.valid = v_s6;
	end

	ppp_div u_div_x (
		.clk    (clk),
		.en     (en),
		.rem_in (remx_s6),
		.d_in   (d_s6),
		.lo_in  (lox_s6),
		.quo    (quox)
	);

	ppp_div u_div_y (
		.clk    (clk),
		.en     (en),
		.rem_in (remy_s6),
		.d_in   (d_s6),
		.lo_in  (loy_s6),
		.quo    (quoy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				side_s[k] <= '0;
			end
		end else if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------- final stage: round, sign, centre, saturate
	function automatic logic [OUT_W:0] finish(input logic [DIV_STEPS-1:0] q,
		input logic zero, input logic ovf, input logic neg, input logic cneg,
		input logic [CEN_W-1:0] center);
		logic [DIV_STEPS:0]      qp1;
		logic [DIV_STEPS-1:0]    mag;
		logic signed [VAL_W-1:0] sv;
		logic signed [VAL_W-1:0] res;
		logic                    bad;
		qp1 = {1'b0, q} + (DIV_STEPS+1)'(1);
		mag = qp1[DIV_STEPS:1];
		sv  = signed'(VAL_W'(mag));
		if (neg) begin
			sv = -sv;
		end
		sv  = sv + signed'(VAL_W'({center, 16'h0000}));
		bad = 1'b1;
		priority if (zero) begin
			res = cneg ? SAT_LO : SAT_HI;
		end else if (ovf) begin
			res = neg ? SAT_LO : SAT_HI;
		end else if (sv > SAT_HI) begin
			res = SAT_HI;
		end else if (sv < SAT_LO) begin
			res = SAT_LO;
		end else begin
			res = sv;
			bad = 1'b0;
		end
		return {bad, res[OUT_W-1:0]};
	endfunction

	side_t            side_l;
	logic [OUT_W:0]   fin_x, fin_y;
	logic             v_out_q;

	assign side_l = side_s[DIV_STEPS-1];
	assign fin_x  = finish(quox, side_l.zero, side_l.ovf_x, side_l.neg_x, side_l.cneg_x,
		center_x_q);
	assign fin_y  = finish(quoy, side_l.zero, side_l.ovf_y, side_l.neg_y, side_l.cneg_y,
		center_y_q);

	// advance everything whenever the output register is free or being drained
	assign en = !v_out_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= side_l.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.pixel_u   <= signed'(fin_x[OUT_W-1:0]);
			out_ch.pixel_v   <= signed'(fin_y[OUT_W-1:0]);
			out_ch.bad_depth <= fin_x[OUT_W] | fin_y[OUT_W];
		end
	end

	assign out_ch.valid = v_out_q;

endmodule
`default_nettype wire
